@@ rtl/core/msps_pkg.sv @@
// Shared types, codes and coil tables for the multi-motor phase sequencer.
// No dependencies; imported by the lane and the top level.
package msps_pkg;

    localparam int CFG_W  = 4;
    localparam int COIL_W = 4;

    typedef enum logic [1:0] {
        CFG_CONFIGURED = 2'd0,
        CFG_REVERSE    = 2'd1,
        CFG_TWO_WIRE   = 2'd2,
        CFG_SHIFTER    = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_TICK    = 2'd0,
        MODE_CMD     = 2'd1,
        MODE_CLEAR   = 2'd2,
        MODE_ALL_OFF = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_OFF   = 3'd1,
        CMD_FWD   = 3'd2,
        CMD_BWD   = 3'd3,
        CMD_RESET = 3'd4
    } t_cmd;

    typedef struct packed {
        logic configured;
        logic reverse;
        logic two_wire;
        logic shifter;
    } t_motor_cfg;

    typedef struct packed {
        logic  accept;
        t_mode mode;
        logic  cmd_ok;
        t_cmd  code;
        logic  [2:0] sel;
        logic  all_off;
    } t_lane_ctl;

    function automatic logic [COIL_W-1:0] four_wire_pat(input logic [1:0] idx);
        logic [COIL_W-1:0] pat;
        case (idx)
            2'd0:    pat = 4'b1001;
            2'd1:    pat = 4'b0011;
            2'd2:    pat = 4'b0110;
            2'd3:    pat = 4'b1100;
            default: pat = 4'b0000;
        endcase
        return pat;
    endfunction

    function automatic logic [COIL_W-1:0] two_wire_pat(input logic [1:0] idx);
        logic [COIL_W-1:0] pat;
        case (idx)
            2'd0:    pat = 4'b0000;
            2'd1:    pat = 4'b0001;
            2'd2:    pat = 4'b0011;
            2'd3:    pat = 4'b0010;
            default: pat = 4'b0000;
        endcase
        return pat;
    endfunction

endpackage

@@ rtl/core/msps_lane.sv @@
// One motor lane: phase, command and step count registers, and coil lines
// derived from the next state. Depends on msps_pkg.
module msps_lane #(
    parameter int IDX        = 0,
    parameter int COUNT_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  msps_pkg::t_lane_ctl      i_ctl,
    input  msps_pkg::t_motor_cfg     i_cfg,
    input  logic [COUNT_BITS-1:0]    i_count,
    output logic                     o_live,
    output logic [msps_pkg::COIL_W-1:0] o_coil
);
    import msps_pkg::*;

    logic [1:0]            r_phase, n_phase;
    t_cmd                  r_cmd, n_cmd;
    logic [COUNT_BITS-1:0] r_steps, n_steps;
    logic [COUNT_BITS-1:0] steps_dec;
    logic                  stepping;
    logic                  step_up;
    logic                  hit;

    assign steps_dec = r_steps - COUNT_BITS'(1);
    assign stepping  = i_cfg.configured && (r_steps != '0);
    assign o_live    = stepping && (steps_dec != '0);
    assign step_up   = (r_cmd == CMD_FWD) ^ i_cfg.reverse;
    assign hit       = i_ctl.cmd_ok && i_cfg.configured && (i_ctl.sel == 3'(IDX));

    always_comb begin
        n_phase = r_phase;
        n_cmd   = r_cmd;
        n_steps = r_steps;
        if (i_ctl.accept) begin
            case (i_ctl.mode)
                MODE_TICK: begin
                    if (stepping) begin
                        if (r_cmd == CMD_FWD || r_cmd == CMD_BWD) begin
                            n_phase = r_phase + (step_up ? 2'd1 : 2'd3);
                        end
                        n_steps = steps_dec;
                    end
                end
                MODE_CMD: begin
                    if (hit) begin
                        case (i_ctl.code)
                            CMD_OFF: begin
                                n_cmd   = CMD_OFF;
                                n_steps = COUNT_BITS'(1);
                            end
                            CMD_RESET: begin
                                n_phase = 2'd0;
                                n_cmd   = CMD_NONE;
                                n_steps = '0;
                            end
                            default: begin
                                n_cmd   = i_ctl.code;
                                n_steps = i_count;
                            end
                        endcase
                    end
                end
                MODE_CLEAR: begin
                    n_cmd   = CMD_NONE;
                    n_steps = '0;
                end
                default: begin
                end
            endcase
            if (i_ctl.all_off && i_cfg.configured) begin
                n_phase = 2'd0;
                n_cmd   = CMD_OFF;
                n_steps = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'd0;
            r_cmd   <= CMD_OFF;
            r_steps <= '0;
        end else begin
            r_phase <= n_phase;
            r_cmd   <= n_cmd;
            r_steps <= n_steps;
        end
    end

    always_comb begin
        if (!i_cfg.configured || n_cmd == CMD_OFF) begin
            o_coil = '0;
        end else if (i_cfg.shifter) begin
            o_coil = (n_cmd == CMD_NONE) ? '0 : four_wire_pat(n_phase);
        end else if (i_cfg.two_wire) begin
            o_coil = two_wire_pat(n_phase);
        end else begin
            o_coil = four_wire_pat(n_phase);
        end
    end

endmodule

@@ rtl/core/multi_stepper_phase_sequencer_top.sv @@
// Top level of the multi-motor full-step phase sequencer.
// Depends on msps_pkg and msps_lane.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one item: mode, motor
//   select, command code and step count. Ticks advance every configured motor
//   with steps left; commands set one motor; clear acts on all, all-off on all configured.
//   Output channel (o_out_valid / i_out_ready) returns one result per item:
//   the coil lines of up to four motors after the item, and all_done.
//   Config channel (i_cfg_valid / o_cfg_ready) writes the four motor masks;
//   always ready; users must write it only while the block is idle (unchecked).
// Timing:
//   All motor lanes update in parallel in the accepting cycle; the result is
//   registered in the output entry, or in the skid entry while one waits.
//   One item per cycle while results are taken (single lane state update).
//   A two-entry output buffer lets one more item in while a result waits;
//   with both entries full o_in_ready drops until the receiver takes one.
// Reset:
//   Synchronous, active low: masks clear, every motor goes to phase zero,
//   command off, no steps; the output buffer empties.
module multi_stepper_phase_sequencer_top #(
    parameter int NUM_MOTORS = 4,
    parameter int COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [2:0]  i_motor_select,
    input  logic [2:0]  i_command_code,
    input  logic [15:0] i_step_count,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_coil_drive,
    output logic        o_all_done,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [msps_pkg::CFG_W-1:0] i_cfg_data
);
    import msps_pkg::*;

    localparam int DRIVE_W = CFG_W * COIL_W;

    logic [CFG_W-1:0] r_cfg_mask, r_rev_mask, r_two_mask, r_shf_mask;

    logic             in_acc;
    t_mode            mode;
    t_cmd             code;
    logic             done;
    t_lane_ctl        ctl;
    logic [NUM_MOTORS-1:0] live;
    logic [COIL_W-1:0]     coil [NUM_MOTORS];
    logic [DRIVE_W-1:0]    drive;

    logic               r_out_v, r_skid_v;
    logic [DRIVE_W-1:0] r_out_drive, r_skid_drive;
    logic               r_out_done, r_skid_done;
    logic               out_take;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_mask <= '0;
            r_rev_mask <= '0;
            r_two_mask <= '0;
            r_shf_mask <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_CONFIGURED: r_cfg_mask <= i_cfg_data;
                CFG_REVERSE:    r_rev_mask <= i_cfg_data;
                CFG_TWO_WIRE:   r_two_mask <= i_cfg_data;
                CFG_SHIFTER:    r_shf_mask <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_in_ready = !r_skid_v;
    assign in_acc     = i_in_valid && o_in_ready;
    assign mode       = t_mode'(i_mode);
    assign code       = t_cmd'(i_command_code);
    assign done       = (mode == MODE_TICK) && !(|live);

    always_comb begin
        ctl.accept  = in_acc;
        ctl.mode    = mode;
        ctl.cmd_ok  = (mode == MODE_CMD) && (code == CMD_OFF || code == CMD_FWD
                      || code == CMD_BWD || code == CMD_RESET);
        ctl.code    = code;
        ctl.sel     = i_motor_select;
        ctl.all_off = done || (mode == MODE_ALL_OFF);
    end

    for (genvar g = 0; g < NUM_MOTORS; g++) begin : g_lane
        t_motor_cfg lane_cfg;
        if (g < CFG_W) begin : g_wired
            assign lane_cfg.configured = r_cfg_mask[g];
            assign lane_cfg.reverse    = r_rev_mask[g];
            assign lane_cfg.two_wire   = r_two_mask[g];
            assign lane_cfg.shifter    = r_shf_mask[g];
        end else begin : g_unwired
            assign lane_cfg = '0;
        end

        msps_lane #(
            .IDX        (g),
            .COUNT_BITS (COUNT_BITS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_cfg   (lane_cfg),
            .i_count (COUNT_BITS'(i_step_count)),
            .o_live  (live[g]),
            .o_coil  (coil[g])
        );
    end

    for (genvar g = 0; g < CFG_W; g++) begin : g_drive
        if (g < NUM_MOTORS) begin : g_used
            assign drive[g*COIL_W +: COIL_W] = coil[g];
        end else begin : g_empty
            assign drive[g*COIL_W +: COIL_W] = '0;
        end
    end

    assign out_take = r_out_v && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v && out_take) begin
            r_skid_v <= 1'b0;
        end else if (!r_out_v || out_take) begin
            r_out_v <= in_acc;
        end else if (in_acc) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v && out_take) begin
            r_out_drive <= r_skid_drive;
            r_out_done  <= r_skid_done;
        end else if (!r_out_v || out_take) begin
            r_out_drive <= drive;
            r_out_done  <= done;
        end else if (in_acc) begin
            r_skid_drive <= drive;
            r_skid_done  <= done;
        end
    end

    assign o_out_valid  = r_out_v;
    assign o_coil_drive = 16'(r_out_drive);
    assign o_all_done   = r_out_done;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry held without an output entry");

    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && !i_out_ready))
        else $error("skid entry filled without a stalled receiver");

    a_done_coils_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_all_done) |-> (o_coil_drive == 16'd0))
        else $error("all_done result with coils still driven");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for multi_stepper_phase_sequencer_top: directed and random items
// under varied valid/ready pressure, each result checked against an in-bench motor model.
// Depends on msps_pkg and the sequencer RTL.
module tb;
    import msps_pkg::*;

    localparam int MOTORS = 4;
    localparam int LIMIT  = 200000;
    localparam logic [15:0] FULL_STEP_SEQ = {4'b1100, 4'b0110, 4'b0011, 4'b1001};
    localparam logic [15:0] TWO_WIRE_SEQ  = {4'b0010, 4'b0011, 4'b0001, 4'b0000};

    typedef struct packed {
        logic [15:0] coil_drive;
        logic        all_done;
    } t_drive_result;

    logic             i_clk          = 1'b0;
    logic             i_rst_n        = 1'b0;
    logic             i_in_valid     = 1'b0;
    logic             o_in_ready;
    t_mode            i_mode         = MODE_TICK;
    logic [2:0]       i_motor_select = '0;
    logic [2:0]       i_command_code = '0;
    logic [15:0]      i_step_count   = '0;
    logic             o_out_valid;
    logic             i_out_ready    = 1'b0;
    logic [15:0]      o_coil_drive;
    logic             o_all_done;
    logic             i_cfg_valid    = 1'b0;
    logic             o_cfg_ready;
    t_cfg_idx         i_cfg_index    = CFG_CONFIGURED;
    logic [CFG_W-1:0] i_cfg_data     = '0;

    logic [3:0]  cfg_configured;
    logic [3:0]  cfg_reverse;
    logic [3:0]  cfg_two_wire;
    logic [3:0]  cfg_shifter;
    logic [1:0]  mot_phase [MOTORS];
    t_cmd        mot_cmd   [MOTORS];
    logic [15:0] mot_steps [MOTORS];

    t_drive_result drive_expect_q[$];
    int            error_count    = 0;
    int            cycle_count    = 0;
    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;

    multi_stepper_phase_sequencer_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_mode         (i_mode),
        .i_motor_select (i_motor_select),
        .i_command_code (i_command_code),
        .i_step_count   (i_step_count),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_coil_drive   (o_coil_drive),
        .o_all_done     (o_all_done),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic void switch_all_off();
        int n;
        for (n = 0; n < MOTORS; n++) begin
            if (cfg_configured[n]) begin
                mot_phase[n] = 2'd0;
                mot_cmd[n]   = CMD_OFF;
                mot_steps[n] = '0;
            end
        end
    endfunction

    function automatic void sequence_motors(input t_mode mode, input logic [2:0] sel,
                                            input logic [2:0] code, input logic [15:0] count,
                                            output t_drive_result res);
        int         n;
        logic       done;
        logic       up;
        logic [3:0] pat;
        done = 1'b0;
        case (mode)
            MODE_TICK: begin
                done = 1'b1;
                for (n = 0; n < MOTORS; n++) begin
                    if (cfg_configured[n] && mot_steps[n] != 0) begin
                        up = !cfg_reverse[n];
                        if (mot_cmd[n] == CMD_FWD)
                            mot_phase[n] = mot_phase[n] + (up ? 2'd1 : 2'd3);
                        else if (mot_cmd[n] == CMD_BWD)
                            mot_phase[n] = mot_phase[n] + (up ? 2'd3 : 2'd1);
                        mot_steps[n] = mot_steps[n] - 16'd1;
                        if (mot_steps[n] != 0)
                            done = 1'b0;
                    end
                end
                if (done)
                    switch_all_off();
            end
            MODE_CMD: begin
                if (code != CMD_NONE && code <= CMD_RESET && sel < MOTORS
                        && cfg_configured[sel[1:0]]) begin
                    case (code)
                        CMD_OFF: begin
                            mot_cmd[sel[1:0]]   = CMD_OFF;
                            mot_steps[sel[1:0]] = 16'd1;
                        end
                        CMD_RESET: begin
                            mot_phase[sel[1:0]] = 2'd0;
                            mot_cmd[sel[1:0]]   = CMD_NONE;
                            mot_steps[sel[1:0]] = '0;
                        end
                        default: begin
                            mot_cmd[sel[1:0]]   = t_cmd'(code);
                            mot_steps[sel[1:0]] = count;
                        end
                    endcase
                end
            end
            MODE_CLEAR: begin
                for (n = 0; n < MOTORS; n++) begin
                    mot_cmd[n]   = CMD_NONE;
                    mot_steps[n] = '0;
                end
            end
            default: switch_all_off();
        endcase
        res.all_done = done;
        for (n = 0; n < MOTORS; n++) begin
            if (!cfg_configured[n] || mot_cmd[n] == CMD_OFF)
                pat = 4'b0000;
            else if (cfg_shifter[n])
                pat = (mot_cmd[n] == CMD_NONE) ? 4'b0000
                                               : FULL_STEP_SEQ[{mot_phase[n], 2'b00} +: 4];
            else if (cfg_two_wire[n])
                pat = TWO_WIRE_SEQ[{mot_phase[n], 2'b00} +: 4];
            else
                pat = FULL_STEP_SEQ[{mot_phase[n], 2'b00} +: 4];
            res.coil_drive[4*n +: 4] = pat;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        if (error_count < 100)
            $display("mismatch %s: got %h expected %h", what, got, want);
        error_count++;
    endtask

    always @(posedge i_clk) begin : check_results
        t_drive_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (drive_expect_q.size() == 0) begin
                report_mismatch("unexpected item coil_drive", o_coil_drive, 16'h0);
            end else begin
                want = drive_expect_q.pop_front();
                if (o_coil_drive !== want.coil_drive)
                    report_mismatch("coil_drive", o_coil_drive, want.coil_drive);
                if (o_all_done !== want.all_done)
                    report_mismatch("all_done", {15'd0, o_all_done}, {15'd0, want.all_done});
            end
        end
    end

    task automatic send_item(input t_mode mode, input logic [2:0] sel, input logic [2:0] code,
                             input logic [15:0] count);
        t_drive_result res;
        @(negedge i_clk);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid     <= 1'b1;
        i_mode         <= mode;
        i_motor_select <= sel;
        i_command_code <= code;
        i_step_count   <= count;
        do @(posedge i_clk); while (!o_in_ready);
        sequence_motors(mode, sel, code, count, res);
        drive_expect_q.push_back(res);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_CONFIGURED: cfg_configured = data;
            CFG_REVERSE:    cfg_reverse    = data;
            CFG_TWO_WIRE:   cfg_two_wire   = data;
            default:        cfg_shifter    = data;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_masks(input logic [3:0] conf, input logic [3:0] rev,
                               input logic [3:0] two, input logic [3:0] shift);
        write_reg(CFG_CONFIGURED, conf);
        write_reg(CFG_REVERSE, rev);
        write_reg(CFG_TWO_WIRE, two);
        write_reg(CFG_SHIFTER, shift);
    endtask

    // hold off new items until every result is back
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (drive_expect_q.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic test_reset_state();
        send_item(MODE_TICK, 3'd0, CMD_NONE, 16'd0);
        send_item(MODE_CMD, 3'd0, CMD_FWD, 16'd5);
        send_item(MODE_ALL_OFF, 3'd7, 3'd7, 16'hFFFF);
        settle();
    endtask

    task automatic test_commands();
        write_masks(4'hF, 4'h5, 4'h2, 4'h8);
        send_item(MODE_CMD, 3'd0, CMD_FWD, 16'd3);
        send_item(MODE_CMD, 3'd1, CMD_BWD, 16'hFFFF);
        send_item(MODE_CMD, 3'd2, CMD_OFF, 16'd0);
        send_item(MODE_CMD, 3'd3, CMD_NONE, 16'd9);
        send_item(MODE_CMD, 3'd3, CMD_FWD, 16'd2);
        send_item(MODE_CMD, 3'd5, CMD_FWD, 16'd7);
        send_item(MODE_CMD, 3'd0, 3'd7, 16'd4);
        send_item(MODE_TICK, 3'd0, CMD_NONE, 16'd0);
        send_item(MODE_TICK, 3'd0, CMD_NONE, 16'd0);
        send_item(MODE_CMD, 3'd3, CMD_RESET, 16'd0);
        settle();
        send_item(MODE_TICK, 3'd0, CMD_NONE, 16'd0);
        send_item(MODE_CLEAR, 3'd0, CMD_NONE, 16'd0);
        send_item(MODE_TICK, 3'd0, CMD_NONE, 16'd0);
        send_item(MODE_ALL_OFF, 3'd0, CMD_NONE, 16'd0);
        send_item(MODE_CMD, 3'd0, CMD_FWD, 16'd1);
        send_item(MODE_TICK, 3'd0, CMD_NONE, 16'd0);
        settle();
        write_masks(4'hF, 4'hF, 4'hF, 4'h0);
        send_item(MODE_CMD, 3'd1, CMD_FWD, 16'd2);
        send_item(MODE_TICK, 3'd0, CMD_NONE, 16'd0);
        send_item(MODE_TICK, 3'd0, CMD_NONE, 16'd0);
        settle();
    endtask

    task automatic test_unconfigured();
        write_masks(4'h6, 4'h0, 4'h0, 4'h0);
        send_item(MODE_CMD, 3'd0, CMD_FWD, 16'd5);
        send_item(MODE_CMD, 3'd1, CMD_FWD, 16'd4);
        send_item(MODE_CLEAR, 3'd0, CMD_NONE, 16'd0);
        send_item(MODE_TICK, 3'd0, CMD_NONE, 16'd0);
    endtask

    task automatic test_random_phase(input int n_items, input int send_pct, input int stall_pct);
        int          k;
        int          r;
        t_mode       mode;
        logic [2:0]  sel;
        logic [2:0]  code;
        logic [15:0] count;
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        for (k = 0; k < n_items; k++) begin
            if (k % 75 == 0) begin
                settle();
                write_masks(4'($urandom_range(15)), 4'($urandom_range(15)),
                            4'($urandom_range(15)), 4'($urandom_range(15)));
            end
            r     = int'($urandom_range(99));
            sel   = 3'($urandom_range(7));
            code  = 3'($urandom_range(7));
            count = 16'($urandom_range(65535));
            if (r < 45) begin
                mode = MODE_TICK;
            end else if (r < 88) begin
                mode = MODE_CMD;
                if ($urandom_range(9) != 0) begin
                    sel   = 3'($urandom_range(3));
                    code  = 3'($urandom_range(4, 1));
                    count = 16'($urandom_range(6));
                end
            end else if (r < 94) begin
                mode = MODE_CLEAR;
            end else begin
                mode = MODE_ALL_OFF;
            end
            send_item(mode, sel, code, count);
        end
    endtask

    initial begin : watchdog
        while (cycle_count < LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int n;
        cfg_configured = '0;
        cfg_reverse    = '0;
        cfg_two_wire   = '0;
        cfg_shifter    = '0;
        for (n = 0; n < MOTORS; n++) begin
            mot_phase[n] = 2'd0;
            mot_cmd[n]   = CMD_OFF;
            mot_steps[n] = '0;
        end
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_commands();
        test_unconfigured();
        test_random_phase(300, 0, 0);
        test_random_phase(300, 61, 0);
        test_random_phase(300, 0, 61);
        test_random_phase(300, 27, 27);
        settle();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/msps_pkg.sv
rtl/core/msps_lane.sv
rtl/core/multi_stepper_phase_sequencer_top.sv
tb/sv/tb.sv
